// ===== hw/rtl/ps2km_pkg.sv =====
// Shared types, constants and scancode lookup for the PS/2 key-matrix decoder
`timescale 1ns / 1ps

package ps2km_pkg;

	// prefix and modifier scancodes
	localparam logic [7:0] CODE_EXT   = 8'hE0;
	localparam logic [7:0] CODE_BREAK = 8'hF0;
	localparam logic [7:0] CODE_LSHIFT = 8'h12;
	localparam logic [7:0] CODE_RSHIFT = 8'h59;
	localparam logic [7:0] CODE_CTRL  = 8'h14;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// one matrix position
	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} key_t;

	localparam key_t KEY_CAPS = '{row: 3'd0, col: 3'd0};
	localparam key_t KEY_SYM  = '{row: 3'd7, col: 3'd1};

	// result of a table lookup: zero, one or two keys
	typedef struct packed {
		logic [1:0] num;
		key_t       k0;
		key_t       k1;
	} lookup_t;

	// one decoded scancode as handed from front to back
	typedef struct packed {
		logic supp;
		logic two;
		logic pressed;
		key_t k0;
		key_t k1;
	} cmd_t;

	function automatic key_t rc(input logic [2:0] r, input logic [2:0] c);
		key_t k;
		k.row = r;
		k.col = c;
		return k;
	endfunction

	function automatic lookup_t one(input key_t k);
		lookup_t l;
		l.num = 2'd1;
		l.k0  = k;
		l.k1  = KEY_CAPS;
		return l;
	endfunction

	function automatic lookup_t pair(input key_t a, input key_t b);
		lookup_t l;
		l.num = 2'd2;
		l.k0  = a;
		l.k1  = b;
		return l;
	endfunction

	// scancode to key mapping, extended and plain, shift selects symbols
	function automatic lookup_t lookup(input logic [7:0] code, input logic ext,
			input logic sh);
		lookup_t l;
		l.num = 2'd0;
		l.k0  = KEY_CAPS;
		l.k1  = KEY_CAPS;
		if (ext) begin
			case (code)
				8'h75: l = pair(KEY_CAPS, rc(3'd4, 3'd3));
				8'h72: l = pair(KEY_CAPS, rc(3'd4, 3'd4));
				8'h6B: l = pair(KEY_CAPS, rc(3'd3, 3'd4));
				8'h74: l = pair(KEY_CAPS, rc(3'd4, 3'd2));
				default: l.num = 2'd0;
			endcase
		end else begin
			case (code)
				8'h1C: l = one(rc(3'd1, 3'd0));
				8'h32: l = one(rc(3'd7, 3'd4));
				8'h21: l = one(rc(3'd0, 3'd3));
				8'h23: l = one(rc(3'd1, 3'd2));
				8'h24: l = one(rc(3'd2, 3'd2));
				8'h2B: l = one(rc(3'd1, 3'd3));
				8'h34: l = one(rc(3'd1, 3'd4));
				8'h33: l = one(rc(3'd6, 3'd4));
				8'h43: l = one(rc(3'd5, 3'd2));
				8'h3B: l = one(rc(3'd6, 3'd3));
				8'h42: l = one(rc(3'd6, 3'd2));
				8'h4B: l = one(rc(3'd6, 3'd1));
				8'h3A: l = one(rc(3'd7, 3'd2));
				8'h31: l = one(rc(3'd7, 3'd3));
				8'h44: l = one(rc(3'd5, 3'd1));
				8'h4D: l = one(rc(3'd5, 3'd0));
				8'h15: l = one(rc(3'd2, 3'd0));
				8'h2D: l = one(rc(3'd2, 3'd3));
				8'h1B: l = one(rc(3'd1, 3'd1));
				8'h2C: l = one(rc(3'd2, 3'd4));
				8'h3C: l = one(rc(3'd5, 3'd3));
				8'h2A: l = one(rc(3'd0, 3'd4));
				8'h1D: l = one(rc(3'd2, 3'd1));
				8'h22: l = one(rc(3'd0, 3'd2));
				8'h35: l = one(rc(3'd5, 3'd4));
				8'h1A: l = one(rc(3'd0, 3'd1));
				8'h45: l = sh ? pair(KEY_SYM, rc(3'd4, 3'd1)) : one(rc(3'd4, 3'd0));
				8'h16: l = sh ? pair(KEY_SYM, rc(3'd3, 3'd0)) : one(rc(3'd3, 3'd0));
				8'h1E: l = sh ? pair(KEY_SYM, rc(3'd3, 3'd1)) : one(rc(3'd3, 3'd1));
				8'h26: l = sh ? pair(KEY_SYM, rc(3'd3, 3'd2)) : one(rc(3'd3, 3'd2));
				8'h25: l = sh ? pair(KEY_SYM, rc(3'd3, 3'd3)) : one(rc(3'd3, 3'd3));
				8'h2E: l = sh ? pair(KEY_SYM, rc(3'd3, 3'd4)) : one(rc(3'd3, 3'd4));
				8'h36: l = sh ? pair(KEY_SYM, rc(3'd4, 3'd4)) : one(rc(3'd4, 3'd4));
				8'h3D: l = sh ? pair(KEY_SYM, rc(3'd4, 3'd3)) : one(rc(3'd4, 3'd3));
				8'h3E: l = sh ? pair(KEY_SYM, rc(3'd7, 3'd4)) : one(rc(3'd4, 3'd2));
				8'h46: l = sh ? pair(KEY_SYM, rc(3'd4, 3'd2)) : one(rc(3'd4, 3'd1));
				8'h55: l = pair(KEY_SYM, sh ? rc(3'd6, 3'd2) : rc(3'd6, 3'd1));
				8'h4E: l = pair(KEY_SYM, sh ? rc(3'd4, 3'd0) : rc(3'd6, 3'd3));
				8'h4A: l = pair(KEY_SYM, rc(3'd0, 3'd4));
				8'h52: l = pair(KEY_SYM, sh ? rc(3'd5, 3'd0) : rc(3'd4, 3'd3));
				8'h41: l = pair(KEY_SYM, sh ? rc(3'd2, 3'd3) : rc(3'd7, 3'd3));
				8'h49: l = pair(KEY_SYM, sh ? rc(3'd2, 3'd4) : rc(3'd7, 3'd2));
				8'h4C: l = pair(KEY_SYM, sh ? rc(3'd0, 3'd1) : rc(3'd5, 3'd1));
				8'h5A: l = one(rc(3'd6, 3'd0));
				8'h29: l = one(rc(3'd7, 3'd0));
				8'h66: l = pair(KEY_CAPS, rc(3'd4, 3'd0));
				default: l.num = 2'd0;
			endcase
		end
		return l;
	endfunction

endpackage

// ===== hw/rtl/ps2km_front.sv =====
// Front end: takes scancode bytes, tracks prefix and modifier flags, builds commands
`timescale 1ns / 1ps

module ps2km_front
	import ps2km_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_ready,
	input  logic [7:0] scan_code,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       queue_full
);

	logic    ext_q;
	logic    rel_q;
	logic    shift_q;
	logic    ctrl_q;
	logic    xfer;
	logic    is_ext;
	logic    is_break;
	logic    is_shift;
	logic    is_ctrl;
	logic    pressed;
	lookup_t lk;

	assign scan_ready = !queue_full;
	assign xfer       = scan_valid && scan_ready;

	// classify the byte
	assign is_ext   = (scan_code == CODE_EXT);
	assign is_break = (scan_code == CODE_BREAK);
	assign is_shift = !ext_q && ((scan_code == CODE_LSHIFT) || (scan_code == CODE_RSHIFT));
	assign is_ctrl  = !ext_q && (scan_code == CODE_CTRL);
	assign pressed  = !rel_q;
	assign lk       = lookup(scan_code, ext_q, shift_q);

	// build the command for the back end
	always_comb begin
		push_cmd.pressed = pressed;
		push_cmd.supp    = 1'b0;
		push_cmd.two     = 1'b0;
		push_cmd.k0      = lk.k0;
		push_cmd.k1      = lk.k1;
		push             = 1'b0;
		if (is_ext || is_break) begin
			push = 1'b0;
		end else if (is_shift) begin
			push_cmd.k0 = KEY_CAPS;
			push        = xfer;
		end else if (is_ctrl) begin
			push_cmd.k0 = KEY_SYM;
			push        = xfer;
		end else begin
			push_cmd.two  = (lk.num == 2'd2);
			push_cmd.supp = (lk.num == 2'd2) && (lk.k0 == KEY_SYM) && shift_q && !ctrl_q;
			push          = xfer && (lk.num != 2'd0);
		end
	end

	// flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q   <= 1'b0;
			rel_q   <= 1'b0;
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
		end else if (xfer) begin
			if (is_ext) begin
				ext_q <= 1'b1;
			end else if (is_break) begin
				rel_q <= 1'b1;
			end else begin
				ext_q <= 1'b0;
				rel_q <= 1'b0;
				if (is_shift) begin
					shift_q <= pressed;
				end
				if (is_ctrl) begin
					ctrl_q <= pressed;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ps2km_queue.sv =====
// Small command queue between the front and back ends
`timescale 1ns / 1ps

module ps2km_queue
	import ps2km_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if ((push && !full) && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ps2km_back.sv =====
// Back end: expands each command into key events through an output register
`timescale 1ns / 1ps

module ps2km_back
	import ps2km_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       key_valid,
	input  logic       key_ready,
	output logic [2:0] key_row,
	output logic [2:0] key_column,
	output logic       key_down,
	output logic       last_event
);

	logic [1:0] step_q;
	logic       out_valid_q;
	key_t       out_key_q;
	logic       out_down_q;
	logic       out_last_q;
	logic       load;
	logic       is_last;
	key_t       ev_key;
	logic       ev_down;

	assign load    = head_valid && (!out_valid_q || key_ready);
	assign is_last = (step_q == {head_cmd.supp, head_cmd.two});
	assign pop     = load && is_last;

	// pick the event for the current step
	always_comb begin
		ev_key  = head_cmd.k0;
		ev_down = head_cmd.pressed;
		case ({head_cmd.supp, step_q})
			3'b100: begin
				ev_key  = KEY_CAPS;
				ev_down = 1'b0;
			end
			3'b101: ev_key = head_cmd.k0;
			3'b110: ev_key = head_cmd.k1;
			3'b111: begin
				ev_key  = KEY_CAPS;
				ev_down = 1'b1;
			end
			3'b000: ev_key = head_cmd.k0;
			3'b001: ev_key = head_cmd.k1;
			default: ev_key = head_cmd.k0;
		endcase
	end

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= is_last ? 2'd0 : step_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (key_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_key_q  <= ev_key;
			out_down_q <= ev_down;
			out_last_q <= is_last;
		end
	end

	assign key_valid  = out_valid_q;
	assign key_row    = out_key_q.row;
	assign key_column = out_key_q.col;
	assign key_down   = out_down_q;
	assign last_event = out_last_q;

endmodule

// ===== hw/rtl/ps2_scancode_to_key_matrix_unit.sv =====
// PS/2 set-2 scancode to 8x5 key-matrix event decoder, top level
// With queue and output register empty, the command of a scancode is written into
// the command queue, and its first event is then loaded into the output register.
// Throughput: one event per cycle from the back end while key_ready is high; a
// scancode gives 1, 2 or 4 events there, prefixes and unmapped codes give none.
// The front end keeps taking bytes while the command queue has room.
// Reset (arst_n low) clears all flags, empties the queue and clears the output valid.
`timescale 1ns / 1ps

module ps2_scancode_to_key_matrix_unit
	import ps2km_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_ready,
	input  logic [7:0] scan_code,
	output logic       key_valid,
	input  logic       key_ready,
	output logic [2:0] key_row,
	output logic [2:0] key_column,
	output logic       key_down,
	output logic       last_event
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// byte classification and flags
	ps2km_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan_valid),
		.scan_ready (scan_ready),
		.scan_code  (scan_code),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (full)
	);

	// decoupling queue
	ps2km_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// event sequencing
	ps2km_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_row    (key_row),
		.key_column (key_column),
		.key_down   (key_down),
		.last_event (last_event)
	);

endmodule

// ===== hw/rtl/ps2km_checker.sv =====
// Port-level checks for the key-matrix decoder, bound to the top level
`timescale 1ns / 1ps

module ps2km_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       scan_valid,
	input logic       scan_ready,
	input logic [7:0] scan_code,
	input logic       key_valid,
	input logic       key_ready,
	input logic [2:0] key_row,
	input logic [2:0] key_column,
	input logic       key_down,
	input logic       last_event
);

	// a stalled scancode holds its byte
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scan_valid && !scan_ready |=> scan_valid && $stable(scan_code))
		else $error("scancode changed while stalled");

	// a stalled event holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_ready |=> key_valid && $stable(key_row) &&
		$stable(key_column) && $stable(key_down) && $stable(last_event))
		else $error("event changed while stalled");

	// matrix has five columns
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid |-> key_column <= 3'd4)
		else $error("column out of range");

	// input back-pressure only when events are waiting
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_ready |-> key_valid)
		else $error("input stalled with no event pending");

	// a non-final event is followed straight away by the rest of its sequence
	a_nonlast_follow: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_ready && !last_event |=> key_valid)
		else $error("event sequence broken");

endmodule

bind ps2_scancode_to_key_matrix_unit ps2km_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.scan_valid (scan_valid),
	.scan_ready (scan_ready),
	.scan_code  (scan_code),
	.key_valid  (key_valid),
	.key_ready  (key_ready),
	.key_row    (key_row),
	.key_column (key_column),
	.key_down   (key_down),
	.last_event (last_event)
);

// ===== sim/tb_ps2_scancode_to_key_matrix_unit.sv =====
// Self-checking regression bench for the PS/2 scancode to key-matrix decoder
`timescale 1ns / 1ps

module tb_ps2_scancode_to_key_matrix_unit;
	import ps2km_pkg::*;

	localparam int STALL_LIMIT     = 1000;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int TAIL_CYCLES     = 16;

	// scancodes used by the directed tests
	localparam logic [7:0] CODE_A      = 8'h1C;
	localparam logic [7:0] CODE_ONE    = 8'h16;
	localparam logic [7:0] CODE_FOUR   = 8'h25;
	localparam logic [7:0] CODE_EQUALS = 8'h55;
	localparam logic [7:0] CODE_SLASH  = 8'h4A;
	localparam logic [7:0] CODE_BKSP   = 8'h66;
	localparam logic [7:0] CODE_UP     = 8'h75;
	localparam logic [7:0] CODE_LEFT   = 8'h6B;
	localparam logic [7:0] CODE_RIGHT  = 8'h74;
	localparam logic [7:0] CODE_NONE_LO = 8'h00;
	localparam logic [7:0] CODE_NONE_HI = 8'hFF;

	// mapped codes for random typing
	localparam int NUM_PLAIN = 46;
	localparam logic [NUM_PLAIN*8-1:0] PLAIN_CODES = {
		8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
		8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
		8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A, 8'h45, 8'h16, 8'h1E, 8'h26,
		8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h55, 8'h4E, 8'h4A, 8'h52,
		8'h41, 8'h49, 8'h4C, 8'h5A, 8'h29, 8'h66
	};
	localparam logic [4*8-1:0] EXT_CODES = {8'h75, 8'h72, 8'h6B, 8'h74};

	// one expected key-matrix event
	typedef struct packed {
		logic [2:0] row;
		logic [2:0] column;
		logic       down;
		logic       is_last;
	} key_event_t;

	// keys produced by one decoded code
	typedef struct packed {
		logic [1:0] count;
		key_t       lead;
		key_t       trail;
	} key_map_t;

	logic       clk;
	logic       arst_n;
	logic       scan_valid;
	logic       scan_ready;
	logic [7:0] scan_code;
	logic       key_valid;
	logic       key_ready;
	logic [2:0] key_row;
	logic [2:0] key_column;
	logic       key_down;
	logic       last_event;

	// decoder state mirrored by the bench
	logic ext_seen   = 1'b0;
	logic break_seen = 1'b0;
	logic shift_on   = 1'b0;
	logic ctrl_on    = 1'b0;

	key_event_t pending_events[$];
	int         error_count = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	int         sender_gap_max = 0;
	int         ready_stall_max = 0;
	bit         hold_off_req = 1'b0;
	int         idle_cycles = 0;

	ps2_scancode_to_key_matrix_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan_valid),
		.scan_ready (scan_ready),
		.scan_code  (scan_code),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_row    (key_row),
		.key_column (key_column),
		.key_down   (key_down),
		.last_event (last_event)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic key_map_t single_key(input key_t k);
		key_map_t m;
		m.count = 2'd1;
		m.lead  = k;
		m.trail = KEY_CAPS;
		return m;
	endfunction

	function automatic key_map_t symbol_pair(input key_t k);
		key_map_t m;
		m.count = 2'd2;
		m.lead  = KEY_SYM;
		m.trail = k;
		return m;
	endfunction

	function automatic key_map_t caps_pair(input key_t k);
		key_map_t m;
		m.count = 2'd2;
		m.lead  = KEY_CAPS;
		m.trail = k;
		return m;
	endfunction

	// scancode to matrix keys, octal literal is {row, column}
	function automatic key_map_t map_scancode(input logic [7:0] code, input logic ext,
			input logic sh);
		key_map_t m;
		m = '0;
		if (ext) begin
			case (code)
				8'h75: m = caps_pair(6'o43);
				8'h72: m = caps_pair(6'o44);
				8'h6B: m = caps_pair(6'o34);
				8'h74: m = caps_pair(6'o42);
				default: m.count = 2'd0;
			endcase
		end else begin
			case (code)
				8'h1C: m = single_key(6'o10);
				8'h32: m = single_key(6'o74);
				8'h21: m = single_key(6'o03);
				8'h23: m = single_key(6'o12);
				8'h24: m = single_key(6'o22);
				8'h2B: m = single_key(6'o13);
				8'h34: m = single_key(6'o14);
				8'h33: m = single_key(6'o64);
				8'h43: m = single_key(6'o52);
				8'h3B: m = single_key(6'o63);
				8'h42: m = single_key(6'o62);
				8'h4B: m = single_key(6'o61);
				8'h3A: m = single_key(6'o72);
				8'h31: m = single_key(6'o73);
				8'h44: m = single_key(6'o51);
				8'h4D: m = single_key(6'o50);
				8'h15: m = single_key(6'o20);
				8'h2D: m = single_key(6'o23);
				8'h1B: m = single_key(6'o11);
				8'h2C: m = single_key(6'o24);
				8'h3C: m = single_key(6'o53);
				8'h2A: m = single_key(6'o04);
				8'h1D: m = single_key(6'o21);
				8'h22: m = single_key(6'o02);
				8'h35: m = single_key(6'o54);
				8'h1A: m = single_key(6'o01);
				// digit row, shifted gives the symbol variant
				8'h45: m = sh ? symbol_pair(6'o41) : single_key(6'o40);
				8'h16: m = sh ? symbol_pair(6'o30) : single_key(6'o30);
				8'h1E: m = sh ? symbol_pair(6'o31) : single_key(6'o31);
				8'h26: m = sh ? symbol_pair(6'o32) : single_key(6'o32);
				8'h25: m = sh ? symbol_pair(6'o33) : single_key(6'o33);
				8'h2E: m = sh ? symbol_pair(6'o34) : single_key(6'o34);
				8'h36: m = sh ? symbol_pair(6'o44) : single_key(6'o44);
				8'h3D: m = sh ? symbol_pair(6'o43) : single_key(6'o43);
				8'h3E: m = sh ? symbol_pair(6'o74) : single_key(6'o42);
				8'h46: m = sh ? symbol_pair(6'o42) : single_key(6'o41);
				// punctuation is always a symbol pair
				8'h55: m = symbol_pair(sh ? 6'o62 : 6'o61);
				8'h4E: m = symbol_pair(sh ? 6'o40 : 6'o63);
				8'h4A: m = symbol_pair(6'o04);
				8'h52: m = symbol_pair(sh ? 6'o50 : 6'o43);
				8'h41: m = symbol_pair(sh ? 6'o23 : 6'o73);
				8'h49: m = symbol_pair(sh ? 6'o24 : 6'o72);
				8'h4C: m = symbol_pair(sh ? 6'o01 : 6'o51);
				8'h5A: m = single_key(6'o60);
				8'h29: m = single_key(6'o70);
				8'h66: m = caps_pair(6'o40);
				default: m.count = 2'd0;
			endcase
		end
		return m;
	endfunction

	function automatic void queue_event(input key_t k, input logic down);
		key_event_t ev;
		ev.row     = k.row;
		ev.column  = k.col;
		ev.down    = down;
		ev.is_last = 1'b0;
		pending_events.push_back(ev);
	endfunction

	// works out the events that one accepted scancode causes
	function automatic void predict_key_events(input logic [7:0] code);
		key_map_t   m;
		logic       down;
		logic       modifier;
		logic       wrap_caps;
		int         before_count;
		key_event_t ev;
		if (code == CODE_EXT) begin
			ext_seen = 1'b1;
			return;
		end
		if (code == CODE_BREAK) begin
			break_seen = 1'b1;
			return;
		end
		down = !break_seen;
		modifier = 1'b0;
		before_count = pending_events.size();
		if (!ext_seen && (code == CODE_LSHIFT || code == CODE_RSHIFT)) begin
			shift_on = down;
			modifier = 1'b1;
			m = single_key(KEY_CAPS);
		end else if (!ext_seen && code == CODE_CTRL) begin
			ctrl_on = down;
			modifier = 1'b1;
			m = single_key(KEY_SYM);
		end else begin
			m = map_scancode(code, ext_seen, shift_on);
		end
		// symbol pair typed with shift alone: caps lifted around the pair
		wrap_caps = !modifier && m.count == 2'd2 && m.lead == KEY_SYM && shift_on && !ctrl_on;
		if (wrap_caps)
			queue_event(KEY_CAPS, 1'b0);
		if (m.count >= 2'd1)
			queue_event(m.lead, down);
		if (m.count == 2'd2)
			queue_event(m.trail, down);
		if (wrap_caps)
			queue_event(KEY_CAPS, 1'b1);
		if (pending_events.size() > before_count) begin
			ev = pending_events.pop_back();
			ev.is_last = 1'b1;
			pending_events.push_back(ev);
		end
		ext_seen = 1'b0;
		break_seen = 1'b0;
	endfunction

	// one scancode transfer, with bursts and random gaps
	task automatic send_scan(input logic [7:0] code);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (sender_gap_max > 0) begin
				gap = $urandom_range(0, sender_gap_max);
				if (gap > 0) begin
					scan_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		scan_valid <= 1'b1;
		scan_code <= code;
		do @(posedge clk); while (!scan_ready);
		items_sent++;
		predict_key_events(code);
	endtask

	// sender idles until every expected event has come out
	task automatic wait_for_drain();
		scan_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() > 0)
			@(posedge clk);
	endtask

	// receiver stall pattern, plus one long hold-off on request
	initial begin
		key_ready <= 1'b1;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				key_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				key_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				if (ready_stall_max > 0) begin
					key_ready <= 1'b0;
					repeat ($urandom_range(1, ready_stall_max)) @(posedge clk);
				end
			end
		end
	end

	// compare each event transfer against the oldest expectation
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && key_valid && key_ready) begin
			if (pending_events.size() == 0) begin
				error_count++;
				$display("%0t: unexpected key event: row %0d col %0d down %0b last %0b",
					$time, key_row, key_column, key_down, last_event);
			end else begin
				want = pending_events.pop_front();
				if (key_row !== want.row || key_column !== want.column ||
						key_down !== want.down || last_event !== want.is_last) begin
					error_count++;
					$display("%0t: key event mismatch: expected row %0d col %0d down %0b last %0b,",
						$time, want.row, want.column, want.down, want.is_last,
						" got row %0d col %0d down %0b last %0b",
						key_row, key_column, key_down, last_event);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((scan_valid && scan_ready) || (key_valid && key_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("ps2_scancode_to_key_matrix_unit regression: fail");
			$finish;
		end
	end

	// plain keys, punctuation without shift, unmapped extremes
	task automatic test_plain_keys();
		send_scan(CODE_A);
		send_scan(CODE_NONE_LO);
		send_scan(CODE_NONE_HI);
		send_scan(CODE_SLASH);
		send_scan(CODE_BKSP);
	endtask

	// shift and ctrl, caps lifted around symbols, shifted digit four
	task automatic test_shift_and_ctrl();
		send_scan(CODE_LSHIFT);
		send_scan(CODE_FOUR);
		send_scan(CODE_BREAK);
		send_scan(CODE_EQUALS);
		send_scan(CODE_CTRL);
		send_scan(CODE_ONE);
		send_scan(CODE_BREAK);
		send_scan(CODE_CTRL);
		send_scan(CODE_BREAK);
		send_scan(CODE_LSHIFT);
	endtask

	// extended keys, prefix order and repeats, extended modifier codes
	task automatic test_extended_keys();
		send_scan(CODE_EXT);
		send_scan(CODE_UP);
		send_scan(CODE_EXT);
		send_scan(CODE_BREAK);
		send_scan(CODE_RIGHT);
		send_scan(CODE_BREAK);
		send_scan(CODE_EXT);
		send_scan(CODE_EXT);
		send_scan(CODE_LEFT);
		send_scan(CODE_EXT);
		send_scan(CODE_LSHIFT);
	endtask

	// random typing: mostly well-formed make/break sequences, some noise
	task automatic test_random_typing(input int count, input int gap_max, input int stall_max);
		int          target;
		int          pick;
		logic [7:0]  code;
		sender_gap_max = gap_max;
		ready_stall_max = stall_max;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_scan(8'($urandom_range(0, 255)));
			end else if (pick < 22) begin
				if ($urandom_range(0, 1))
					send_scan(CODE_BREAK);
				case ($urandom_range(0, 2))
					0: code = CODE_LSHIFT;
					1: code = CODE_RSHIFT;
					default: code = CODE_CTRL;
				endcase
				send_scan(code);
			end else if (pick < 34) begin
				send_scan(CODE_EXT);
				if ($urandom_range(0, 2) == 0)
					send_scan(CODE_BREAK);
				if ($urandom_range(0, 4) == 0)
					code = 8'($urandom_range(0, 255));
				else
					code = EXT_CODES[$urandom_range(0, 3)*8 +: 8];
				send_scan(code);
			end else begin
				code = PLAIN_CODES[$urandom_range(0, NUM_PLAIN - 1)*8 +: 8];
				send_scan(code);
				if ($urandom_range(0, 1)) begin
					send_scan(CODE_BREAK);
					send_scan(code);
				end
			end
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure_fill();
		sender_gap_max = 0;
		hold_off_req = 1'b1;
		send_scan(CODE_RSHIFT);
		repeat (16)
			send_scan(PLAIN_CODES[$urandom_range(0, NUM_PLAIN - 1)*8 +: 8]);
		send_scan(CODE_BREAK);
		send_scan(CODE_RSHIFT);
		wait_for_drain();
	endtask

	// reset, then the tests in turn
	initial begin
		arst_n <= 1'b0;
		scan_valid <= 1'b0;
		scan_code <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_gap_max = 2;
		ready_stall_max = 3;
		test_plain_keys();
		test_shift_and_ctrl();
		test_extended_keys();
		wait_for_drain();
		test_random_typing(130, 0, 0);
		test_backpressure_fill();
		test_random_typing(130, 6, 4);
		wait_for_drain();
		test_random_typing(130, 3, 15);
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ps2_scancode_to_key_matrix_unit regression: pass");
		else
			$display("ps2_scancode_to_key_matrix_unit regression: fail");
		$finish;
	end

endmodule

// ===== ps2_scancode_to_key_matrix_unit.f =====
hw/rtl/ps2km_pkg.sv
hw/rtl/ps2km_front.sv
hw/rtl/ps2km_queue.sv
hw/rtl/ps2km_back.sv
hw/rtl/ps2_scancode_to_key_matrix_unit.sv
hw/rtl/ps2km_checker.sv
sim/tb_ps2_scancode_to_key_matrix_unit.sv
